FILE: rtl/assert_macros.svh
// Assertion macros shared by the sample rate converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/fpsrc_pkg.sv
// Types and constants of the fixed-point sample rate converter.
package fpsrc_pkg;

  localparam int unsigned BASE_BITS   = 9;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned STEP_W      = 14;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned MUL_B_W     = BASE_BITS + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REG_IDX_W   = ADDR_W - 2;

  localparam logic [STEP_W-1:0]    UNITY    = STEP_W'(1 << BASE_BITS);
  localparam logic [REG_IDX_W-1:0] REG_STEP = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_INT  = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       block_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       run_last;
    logic                       block_done;
  } out_req_t;

  typedef struct packed {
    in_req_t req;
    mode_e   mode;
  } queue_entry_t;

endpackage

FILE: rtl/fpsrc_front.sv
// Front end: accepts input requests, tags them with the step mode and queues them.
`include "assert_macros.svh"

module fpsrc_front #(
  parameter int unsigned QueueDepth = fpsrc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [fpsrc_pkg::STEP_W-1:0]     step_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fpsrc_pkg::in_req_t               in_req_i,
  output logic                             q_valid_o,
  output fpsrc_pkg::queue_entry_t          q_entry_o,
  input  logic                             q_pop_i
);
  import fpsrc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  queue_entry_t    entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  mode_e           mode;

  assign in_stall_o = (count_q == CntW'(QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entry_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    if (step_i == UNITY) begin
      mode = MODE_PASS;
    end else if (step_i < UNITY) begin
      mode = MODE_DEC;
    end else begin
      mode = MODE_INT;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{req: in_req_i, mode: mode};
    end
  end

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(QueueDepth), "queue overfilled")
  `ASSERT_PROP(a_push_fills, clk_i, rst_ni, push && !pop |=> count_q != '0, "queue lost a request")
  `ASSERT_PROP(a_empty_ptrs, clk_i, rst_ni, count_q == '0 |-> wr_ptr_q == rd_ptr_q, "pointer skew")

endmodule

FILE: rtl/fpsrc_back.sv
// Back end: sequences one queued sample through the resampling arithmetic.
`include "assert_macros.svh"

module fpsrc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [fpsrc_pkg::STEP_W-1:0]     step_i,
  input  logic                             reload_i,
  input  logic                             q_valid_i,
  input  fpsrc_pkg::queue_entry_t          q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fpsrc_pkg::out_req_t              out_req_o
);
  import fpsrc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_PASS  = 10'b00_0000_0010,
    ST_DMUL  = 10'b00_0000_0100,
    ST_DACC  = 10'b00_0000_1000,
    ST_DCAR  = 10'b00_0001_0000,
    ST_DTAIL = 10'b00_0010_0000,
    ST_IMUL1 = 10'b00_0100_0000,
    ST_IMUL2 = 10'b00_1000_0000,
    ST_IMIX  = 10'b01_0000_0000,
    ST_IREP  = 10'b10_0000_0000
  } state_e;

  state_e                         state_q, state_d;
  logic signed [SAMPLE_W-1:0]     s_q, s_d;
  logic                           last_q, last_d;
  logic [STEP_W-1:0]              rem_q, rem_d;
  logic signed [SUM_W-1:0]        sum_q, sum_d;
  logic signed [SUM_W-1:0]        prod_q, prod_d;
  logic signed [SAMPLE_W-1:0]     held_q, held_d;
  logic                           out_valid_q, out_valid_d;
  out_req_t                       out_q, out_d;

  logic                           push_ok, finish, emit, more;
  logic signed [SAMPLE_W-1:0]     emit_val;
  logic                           emit_rl, emit_done;
  logic signed [SAMPLE_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]             mul_b;
  logic signed [SAMPLE_W+MUL_B_W:0] mul_full;
  logic signed [SUM_W-1:0]        mul_p, acc;
  logic [STEP_W-1:0]              carry, rem_carry, fresh, rem_int, rep_rem;

  assign push_ok   = !out_valid_q || !out_stall_i;
  assign acc       = sum_q + prod_q;
  assign carry     = step_i - rem_q;
  assign rem_carry = UNITY - carry;
  assign fresh     = UNITY - rem_q;
  assign rem_int   = step_i - fresh;
  assign rep_rem   = rem_q - UNITY;

  always_comb begin
    case (state_q)
      ST_DMUL: begin
        mul_a = s_q;
        mul_b = (rem_q > step_i) ? step_i[MUL_B_W-1:0] : rem_q[MUL_B_W-1:0];
      end
      ST_DACC: begin
        mul_a = s_q;
        mul_b = carry[MUL_B_W-1:0];
      end
      ST_IMUL1: begin
        mul_a = held_q;
        mul_b = rem_q[MUL_B_W-1:0];
      end
      ST_IMUL2: begin
        mul_a = s_q;
        mul_b = fresh[MUL_B_W-1:0];
      end
      default: begin
        mul_a = s_q;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * $signed({1'b0, mul_b});
    mul_p    = mul_full[SUM_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    last_d      = last_q;
    rem_d       = rem_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    held_d      = held_q;
    q_pop_o     = 1'b0;
    finish      = 1'b0;
    emit        = 1'b0;
    emit_val    = s_q;
    emit_rl     = 1'b1;
    emit_done   = 1'b0;
    more        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          s_d     = q_entry_i.req.in_sample;
          last_d  = q_entry_i.req.block_last;
          case (q_entry_i.mode)
            MODE_DEC: state_d = ST_DMUL;
            MODE_INT: state_d = ST_IMUL1;
            default:  state_d = ST_PASS;
          endcase
        end
      end
      ST_PASS: begin
        if (push_ok) begin
          emit      = 1'b1;
          emit_done = last_q;
          finish    = 1'b1;
        end
      end
      ST_DMUL: begin
        prod_d  = mul_p;
        state_d = ST_DACC;
      end
      ST_DACC: begin
        if (rem_q > step_i) begin
          sum_d = acc;
          rem_d = rem_q - step_i;
          if (last_q && ((rem_q - step_i) != UNITY)) begin
            state_d = ST_DTAIL;
          end else begin
            finish = 1'b1;
          end
        end else if (push_ok) begin
          emit      = 1'b1;
          emit_val  = $signed(acc[BASE_BITS +: SAMPLE_W]);
          emit_rl   = !(last_q && (carry != '0));
          emit_done = last_q && (carry == '0);
          prod_d    = mul_p;
          rem_d     = rem_carry;
          state_d   = ST_DCAR;
        end
      end
      ST_DCAR: begin
        sum_d = prod_q;
        if (last_q && (rem_q != UNITY)) begin
          state_d = ST_DTAIL;
        end else begin
          finish = 1'b1;
        end
      end
      ST_DTAIL: begin
        if (push_ok) begin
          emit      = 1'b1;
          emit_val  = $signed(sum_q[BASE_BITS +: SAMPLE_W]);
          emit_done = 1'b1;
          finish    = 1'b1;
        end
      end
      ST_IMUL1: begin
        prod_d  = mul_p;
        state_d = ST_IMUL2;
      end
      ST_IMUL2: begin
        prod_d  = mul_p;
        sum_d   = prod_q;
        state_d = ST_IMIX;
      end
      ST_IMIX: begin
        if (push_ok) begin
          more      = (rem_int >= UNITY) || (last_q && (rem_int != '0));
          emit      = 1'b1;
          emit_val  = $signed(acc[BASE_BITS +: SAMPLE_W]);
          emit_rl   = !more;
          emit_done = !more && last_q;
          held_d    = s_q;
          rem_d     = rem_int;
          sum_d     = '0;
          if (more) begin
            state_d = ST_IREP;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_IREP: begin
        if (push_ok) begin
          emit = 1'b1;
          if (rem_q >= UNITY) begin
            more      = (rep_rem >= UNITY) || (last_q && (rep_rem != '0));
            emit_rl   = !more;
            emit_done = !more && last_q;
            rem_d     = rep_rem;
            finish    = !more;
          end else begin
            emit_val  = '0;
            emit_done = 1'b1;
            finish    = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = ST_IDLE;
    end
    if ((finish && last_q) || reload_i) begin
      rem_d  = (step_i < UNITY) ? UNITY : '0;
      sum_d  = '0;
      held_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = '{out_sample: emit_val, run_last: emit_rl, block_done: emit_done};
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      sum_q       <= '0;
      held_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      sum_q       <= sum_d;
      held_q      <= held_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  `ASSERT_PROP(a_dec_rem, clk_i, rst_ni, state_q == ST_DMUL |-> rem_q <= UNITY && rem_q != '0, "decimation phase out of range")
  `ASSERT_PROP(a_int_rem, clk_i, rst_ni, state_q == ST_IMUL1 |-> rem_q < UNITY, "interpolation phase out of range")
  `ASSERT_PROP(a_done_last, clk_i, rst_ni, out_valid_q && out_q.block_done |-> out_q.run_last, "block end not on run end")
  `ASSERT_PROP(a_pop_busy, clk_i, rst_ni, q_pop_o |=> state_q != ST_IDLE, "popped request dropped")

endmodule

FILE: rtl/fixed_point_sample_rate_converter_top.sv
// Top level of the fixed-point sample rate converter with its step register.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_req_i (sample, block_last)
// out       output     out_valid_o / out_stall_i  out_req_o (sample, run_last, block_done)
// config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A pass-through request steps IDLE, PASS; a decimating one IDLE, DMUL, DACC, then
// optionally DCAR and DTAIL; an interpolating one IDLE, IMUL1, IMUL2, IMIX, then IREP
// per repeated held sample or trailing zero sample. The sequencer shares one multiplier.
// Reset clears all control state and sets the step to 512.
// A step write reloads the phase state in the cycle after the new step is registered.
// The input stalls when the two-entry queue is full; an output stall on a valid result
// holds the result register and the sequencer states that emit a sample.
module fixed_point_sample_rate_converter_top #(
  parameter int unsigned QueueDepth = fpsrc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fpsrc_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fpsrc_pkg::out_req_t              out_req_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpsrc_pkg::ADDR_W-1:0]     paddr,
  input  logic [fpsrc_pkg::DATA_W-1:0]     pwdata,
  output logic [fpsrc_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);
  import fpsrc_pkg::*;

  logic [STEP_W-1:0]    step_q, step_d;
  logic                 reload_q;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_valid, q_pop;
  queue_entry_t         q_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_STEP);
  assign step_d  = cfg_we ? pwdata[STEP_W-1:0] : step_q;
  assign prdata  = (reg_idx == REG_STEP) ? {{(DATA_W - STEP_W){1'b0}}, step_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= UNITY;
      reload_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      reload_q <= cfg_we;
    end
  end

  fpsrc_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  fpsrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_q),
    .reload_i    (reload_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
